// ===== rtl/core/bgd_pkg.sv =====
`default_nettype none

package bgd_pkg;

   localparam int StableWidth = 10;
   localparam int HoldWidth   = 8;
   localparam int ArgWidth    = 13;
   localparam int CsrWidth    = 10;

   localparam logic [StableWidth-1:0] STABLE_SAMPLES_RESET = 10'd1000;
   localparam logic [HoldWidth-1:0]   HOLD_COUNT_RESET     = 8'd189;
   localparam logic [HoldWidth-1:0]   HOLD_MAX             = 8'hFF;

   localparam logic signed [ArgWidth-1:0] ARG_ZERO      = 13'sd0;
   localparam logic signed [ArgWidth-1:0] ARG_MODE_LEFT = 13'sd1;
   localparam logic signed [ArgWidth-1:0] ARG_MODE_RGHT = 13'sd2;
   localparam logic signed [ArgWidth-1:0] ARG_MODE_BOTH = 13'sd3;
   localparam logic signed [ArgWidth-1:0] ARG_HOUR      = 13'sd3600;
   localparam logic signed [ArgWidth-1:0] ARG_MINUTE    = 13'sd60;
   localparam logic signed [ArgWidth-1:0] ARG_STEP_UP   = 13'sd1;
   localparam logic signed [ArgWidth-1:0] ARG_STEP_DOWN = -13'sd1;

   typedef enum logic [2:0] {
      CMD_NONE         = 3'd0,
      CMD_SET_MODE     = 3'd1,
      CMD_CHANGE_TIME  = 3'd2,
      CMD_CHANGE_ALARM = 3'd3,
      CMD_ALARM_TYPE   = 3'd4,
      CMD_CUSTOMIZE    = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_NORMAL    = 2'd0,
      MODE_SET_TIME  = 2'd1,
      MODE_SET_ALARM = 2'd2,
      MODE_CUSTOMIZE = 2'd3
   } mode_type;

   // pins are active low: bit1 left, bit0 right
   typedef enum logic [1:0] {
      LVL_BOTH  = 2'b00,
      LVL_LEFT  = 2'b01,
      LVL_RIGHT = 2'b10,
      LVL_NONE  = 2'b11
   } level_type;

   typedef enum logic {
      CSR_STABLE_SAMPLES = 1'b0,
      CSR_HOLD_COUNT     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       accept;
      logic [1:0] levels;
   } deb_out_type;

   function automatic logic [HoldWidth-1:0] sat_inc(input logic [HoldWidth-1:0] v);
      sat_inc = (v == HOLD_MAX) ? HOLD_MAX : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/button_gesture_decoder_top.sv =====
`default_nettype none

// Two-button gesture decoder. Each req transaction carries one raw sample of the
// active-low left and right pins plus the current clock mode. Samples are
// debounced: a reading is accepted once it has stayed unchanged for csr
// stable_samples (index 0) further samples, and each accepted reading yields exactly
// one rsp transaction with the silence flag, command, argument and the
// debounced level; other samples yield nothing. csr hold_count (index 1) sets
// how many accepted readings a press must last in normal mode. One sample can be
// taken every cycle: a sample sits in the input register while the debounce
// counter and gesture state update in a single pass, and the result lands in
// the output register, so rsp_valid rises in the cycle after the debouncer
// accepts the reading. The input side stalls only while the output
// register holds an untaken result and the current sample produces another.
module button_gesture_decoder_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_left_level,
   input  wire logic                                 req_right_level,
   input  wire logic [1:0]                           req_mode,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_silence,
   output logic [2:0]                                rsp_command,
   output logic signed [bgd_pkg::ArgWidth-1:0]       rsp_argument,
   output logic [1:0]                                rsp_debounced_state,
   input  wire logic                                 csr_we,
   input  wire logic                                 csr_index,
   input  wire logic [bgd_pkg::CsrWidth-1:0]         csr_wdata
);
   import bgd_pkg::*;

   logic [StableWidth-1:0] stable_samples_ff;
   logic [HoldWidth-1:0]   hold_count_ff;

   logic                   in_valid_ff;
   logic [1:0]             in_levels_ff;
   logic [1:0]             in_mode_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_stop_ff;
   logic [2:0]             rsp_cmd_ff;
   logic signed [ArgWidth-1:0] rsp_arg_ff;
   logic [1:0]             rsp_state_ff;

   deb_out_type            deb_out;
   logic                   silence;
   logic [2:0]             command;
   logic signed [ArgWidth-1:0] argument;
   logic                   out_free;
   logic                   proc_fire;
   logic                   req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proc_fire = in_valid_ff && (!deb_out.accept || out_free);
   assign req_stall = in_valid_ff && !proc_fire;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_samples_ff <= STABLE_SAMPLES_RESET;
         hold_count_ff     <= HOLD_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STABLE_SAMPLES: stable_samples_ff <= csr_wdata[StableWidth-1:0];
            default:            hold_count_ff     <= csr_wdata[HoldWidth-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (proc_fire || !in_valid_ff) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_levels_ff <= {req_left_level, req_right_level};
         in_mode_ff   <= req_mode;
      end
   end

   bgd_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .en             (proc_fire),
      .levels         (in_levels_ff),
      .stable_samples (stable_samples_ff),
      .deb_out        (deb_out)
   );

   bgd_classify u_classify (
      .clock      (clock),
      .reset      (reset),
      .en         (proc_fire),
      .deb_out    (deb_out),
      .mode       (in_mode_ff),
      .hold_count (hold_count_ff),
      .silence    (silence),
      .command    (command),
      .argument   (argument)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc_fire && deb_out.accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire && deb_out.accept) begin
         rsp_stop_ff  <= silence;
         rsp_cmd_ff   <= command;
         rsp_arg_ff   <= argument;
         rsp_state_ff <= deb_out.levels;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_silence         = rsp_stop_ff;
   assign rsp_command         = rsp_cmd_ff;
   assign rsp_argument        = rsp_arg_ff;
   assign rsp_debounced_state = rsp_state_ff;

`ifndef ASSERT_OFF
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      proc_fire && deb_out.accept |=> rsp_valid_ff)
      else $error("accepted reading produced no transaction");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      proc_fire && deb_out.accept |-> !rsp_valid_ff || !rsp_stall)
      else $error("pending result overwritten");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bgd_debounce.sv =====
`default_nettype none

module bgd_debounce (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  wire logic [1:0]                       levels,
   input  wire logic [bgd_pkg::StableWidth-1:0]  stable_samples,
   output bgd_pkg::deb_out_type                  deb_out
);
   import bgd_pkg::*;

   logic                   window_open_ff, window_open_in;
   logic [1:0]             ref_levels_ff, ref_levels_in;
   logic [StableWidth-1:0] stable_left_ff, stable_left_in;
   logic                   accept;

   assign accept = window_open_ff && (levels == ref_levels_ff) && (stable_left_ff <= 1);
   assign deb_out.accept = accept;
   assign deb_out.levels = levels;

   always_comb begin
      window_open_in = window_open_ff;
      ref_levels_in  = ref_levels_ff;
      stable_left_in = stable_left_ff;
      priority if (!window_open_ff || levels != ref_levels_ff) begin
         // new window, or reading changed: restart the count
         window_open_in = 1'b1;
         ref_levels_in  = levels;
         stable_left_in = stable_samples;
      end else if (stable_left_ff > 1) begin
         stable_left_in = stable_left_ff - 1'b1;
      end else begin
         window_open_in = 1'b0;
         stable_left_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_open_ff <= 1'b0;
         ref_levels_ff  <= '0;
         stable_left_ff <= '0;
      end else if (en) begin
         window_open_ff <= window_open_in;
         ref_levels_ff  <= ref_levels_in;
         stable_left_ff <= stable_left_in;
      end
   end

`ifndef ASSERT_OFF
   a_closed_window_empty: assert property (@(posedge clock) disable iff (reset)
      !window_open_ff |-> stable_left_ff == '0)
      else $error("closed window holds a count");
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      en && accept |=> !window_open_ff)
      else $error("window still open after accepted reading");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bgd_classify.sv =====
`default_nettype none

module bgd_classify (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire bgd_pkg::deb_out_type                 deb_out,
   input  wire logic [1:0]                           mode,
   input  wire logic [bgd_pkg::HoldWidth-1:0]        hold_count,
   output logic                                      silence,
   output logic [2:0]                                command,
   output logic signed [bgd_pkg::ArgWidth-1:0]       argument
);
   import bgd_pkg::*;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_LEFT  = 2'd1,
      PEND_RIGHT = 2'd2
   } pend_type;

   logic [HoldWidth-1:0] left_hold_ff, left_hold_in;
   logic [HoldWidth-1:0] right_hold_ff, right_hold_in;
   logic [HoldWidth-1:0] both_hold_ff, both_hold_in;
   pend_type             pending_ff, pending_in;
   logic                 both_pending_ff, both_pending_in;
   logic                 reset_pending_ff, reset_pending_in;
   logic                 is_normal;
   logic                 take;

   assign is_normal = (mode == MODE_NORMAL);
   assign take      = en && deb_out.accept;

   always_comb begin
      silence          = 1'b0;
      command          = CMD_NONE;
      argument         = ARG_ZERO;
      left_hold_in     = left_hold_ff;
      right_hold_in    = right_hold_ff;
      both_hold_in     = both_hold_ff;
      pending_in       = pending_ff;
      both_pending_in  = both_pending_ff;
      reset_pending_in = reset_pending_ff;
      unique case (deb_out.levels)
         LVL_LEFT: begin
            pending_in = PEND_LEFT;
            if (is_normal) begin
               silence      = 1'b1;
               left_hold_in = sat_inc(left_hold_ff);
               if (left_hold_in < hold_count) pending_in = PEND_NONE;
            end
         end
         LVL_RIGHT: begin
            pending_in = PEND_RIGHT;
            if (is_normal) begin
               silence       = 1'b1;
               right_hold_in = sat_inc(right_hold_ff);
               if (right_hold_in < hold_count) pending_in = PEND_NONE;
            end
         end
         LVL_BOTH: begin
            unique case (mode)
               MODE_NORMAL: begin
                  both_hold_in    = sat_inc(both_hold_ff);
                  both_pending_in = (both_hold_in >= hold_count);
               end
               MODE_CUSTOMIZE: begin
                  silence = 1'b1;
                  command = CMD_CUSTOMIZE;
               end
               default: reset_pending_in = 1'b1;
            endcase
         end
         default: begin
            // release: reset, then both, then single button
            left_hold_in  = '0;
            right_hold_in = '0;
            both_hold_in  = '0;
            priority if (reset_pending_ff) begin
               reset_pending_in = 1'b0;
               silence          = 1'b1;
               command          = CMD_SET_MODE;
            end else if (both_pending_ff) begin
               both_pending_in = 1'b0;
               if (is_normal) begin
                  command  = CMD_SET_MODE;
                  argument = ARG_MODE_BOTH;
               end
            end else if (pending_ff == PEND_LEFT || pending_ff == PEND_RIGHT) begin
               unique case (mode)
                  MODE_NORMAL: begin
                     command  = CMD_SET_MODE;
                     argument = (pending_ff == PEND_LEFT) ? ARG_MODE_LEFT : ARG_MODE_RGHT;
                  end
                  MODE_SET_TIME: begin
                     command  = CMD_CHANGE_TIME;
                     argument = (pending_ff == PEND_LEFT) ? ARG_HOUR : ARG_MINUTE;
                  end
                  MODE_SET_ALARM: begin
                     command  = CMD_CHANGE_ALARM;
                     argument = (pending_ff == PEND_LEFT) ? ARG_HOUR : ARG_MINUTE;
                  end
                  default: begin
                     command  = CMD_ALARM_TYPE;
                     argument = (pending_ff == PEND_LEFT) ? ARG_STEP_DOWN : ARG_STEP_UP;
                  end
               endcase
            end
            pending_in = PEND_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_hold_ff     <= '0;
         right_hold_ff    <= '0;
         both_hold_ff     <= '0;
         pending_ff       <= PEND_NONE;
         both_pending_ff  <= 1'b0;
         reset_pending_ff <= 1'b0;
      end else if (take) begin
         left_hold_ff     <= left_hold_in;
         right_hold_ff    <= right_hold_in;
         both_hold_ff     <= both_hold_in;
         pending_ff       <= pending_in;
         both_pending_ff  <= both_pending_in;
         reset_pending_ff <= reset_pending_in;
      end
   end

`ifndef ASSERT_OFF
   a_none_no_arg: assert property (@(posedge clock) disable iff (reset)
      take && command == CMD_NONE |-> argument == ARG_ZERO)
      else $error("argument set without a command");
   a_reset_first: assert property (@(posedge clock) disable iff (reset)
      take && deb_out.levels == LVL_NONE && reset_pending_ff
      |-> silence && command == CMD_SET_MODE)
      else $error("pending reset not taken first on release");
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      take && deb_out.levels == LVL_NONE
      |=> left_hold_ff == '0 && right_hold_ff == '0 && both_hold_ff == '0)
      else $error("hold timers not cleared on release");
`endif

endmodule

`default_nettype wire

// ===== tb/gesture_check_pkg.sv =====
package gesture_check_pkg;
   import bgd_pkg::*;

   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_LEFT  = 2'd1;
   localparam logic [1:0] PEND_RIGHT = 2'd2;

   typedef struct {
      logic                        silence;
      cmd_type                     command;
      logic signed [ArgWidth-1:0]  argument;
      level_type                   level;
   } decision_type;

   class gesture_scoreboard;
      logic [StableWidth-1:0] stable_samples;
      logic [HoldWidth-1:0]   hold_count;

      bit                     window_open;
      level_type              window_level;
      logic [StableWidth-1:0] samples_to_go;
      logic [HoldWidth-1:0]   left_hold;
      logic [HoldWidth-1:0]   right_hold;
      logic [HoldWidth-1:0]   both_hold;
      logic [1:0]             pending_button;
      bit                     both_pending;
      bit                     reset_pending;

      decision_type expected_decisions[$];
      int samples_seen;
      int decisions_checked;
      int errors;
      int command_count [6];

      function new();
         stable_samples = STABLE_SAMPLES_RESET;
         hold_count     = HOLD_COUNT_RESET;
         window_open    = 1'b0;
         window_level   = LVL_BOTH;
         samples_to_go  = '0;
         left_hold      = '0;
         right_hold     = '0;
         both_hold      = '0;
         pending_button = PEND_NONE;
         both_pending   = 1'b0;
         reset_pending  = 1'b0;
         samples_seen   = 0;
         decisions_checked = 0;
         errors         = 0;
         foreach (command_count[i]) command_count[i] = 0;
      endfunction

      function void set_register(csr_index_type idx, int value);
         case (idx)
            CSR_STABLE_SAMPLES: stable_samples = value[StableWidth-1:0];
            default:            hold_count     = value[HoldWidth-1:0];
         endcase
      endfunction

      function logic [HoldWidth-1:0] hold_step(logic [HoldWidth-1:0] v);
         return (v == 8'hFF) ? v : v + 8'd1;
      endfunction

      function int outstanding();
         return expected_decisions.size();
      endfunction

      // debounce one sample and, on an accepted reading, queue the decision it yields
      function void note_sample(logic left_pin, logic right_pin, mode_type m);
         level_type lvl;
         decision_type d;
         bit go_left;
         samples_seen++;
         lvl = level_type'({left_pin, right_pin});
         if (!window_open) begin
            window_open   = 1'b1;
            window_level  = lvl;
            samples_to_go = stable_samples;
            return;
         end
         if (lvl != window_level) begin
            window_level  = lvl;
            samples_to_go = stable_samples;
            return;
         end
         if (samples_to_go > 1) begin
            samples_to_go--;
            return;
         end
         samples_to_go = '0;
         window_open   = 1'b0;

         d.silence  = 1'b0;
         d.command  = CMD_NONE;
         d.argument = ARG_ZERO;
         d.level    = lvl;
         case (lvl)
            LVL_LEFT: begin
               pending_button = PEND_LEFT;
               if (m == MODE_NORMAL) begin
                  d.silence = 1'b1;
                  left_hold = hold_step(left_hold);
                  if (left_hold < hold_count) pending_button = PEND_NONE;
               end
            end
            LVL_RIGHT: begin
               pending_button = PEND_RIGHT;
               if (m == MODE_NORMAL) begin
                  d.silence = 1'b1;
                  right_hold = hold_step(right_hold);
                  if (right_hold < hold_count) pending_button = PEND_NONE;
               end
            end
            LVL_BOTH: begin
               if (m == MODE_NORMAL) begin
                  both_hold    = hold_step(both_hold);
                  both_pending = (both_hold >= hold_count);
               end else if (m == MODE_CUSTOMIZE) begin
                  d.silence = 1'b1;
                  d.command = CMD_CUSTOMIZE;
               end else begin
                  reset_pending = 1'b1;
               end
            end
            default: begin
               left_hold  = '0;
               right_hold = '0;
               both_hold  = '0;
               // release: reset gesture wins over both, both over a single button
               if (reset_pending) begin
                  reset_pending = 1'b0;
                  d.silence     = 1'b1;
                  d.command     = CMD_SET_MODE;
               end else if (both_pending) begin
                  both_pending = 1'b0;
                  if (m == MODE_NORMAL) begin
                     d.command  = CMD_SET_MODE;
                     d.argument = ARG_MODE_BOTH;
                  end
               end else if (pending_button != PEND_NONE) begin
                  go_left = (pending_button == PEND_LEFT);
                  case (m)
                     MODE_NORMAL: begin
                        d.command  = CMD_SET_MODE;
                        d.argument = go_left ? ARG_MODE_LEFT : ARG_MODE_RGHT;
                     end
                     MODE_SET_TIME: begin
                        d.command  = CMD_CHANGE_TIME;
                        d.argument = go_left ? ARG_HOUR : ARG_MINUTE;
                     end
                     MODE_SET_ALARM: begin
                        d.command  = CMD_CHANGE_ALARM;
                        d.argument = go_left ? ARG_HOUR : ARG_MINUTE;
                     end
                     default: begin
                        d.command  = CMD_ALARM_TYPE;
                        d.argument = go_left ? ARG_STEP_DOWN : ARG_STEP_UP;
                     end
                  endcase
               end
               pending_button = PEND_NONE;
            end
         endcase
         expected_decisions.push_back(d);
      endfunction

      function void check_decision(logic stop, logic [2:0] cmd,
                                   logic signed [ArgWidth-1:0] arg, logic [1:0] lvl);
         decision_type want;
         if (expected_decisions.size() == 0) begin
            $display("%0t: unexpected decision silence=%0b cmd=%0d arg=%0d state=%b",
                     $time, stop, cmd, arg, lvl);
            errors++;
            return;
         end
         want = expected_decisions.pop_front();
         decisions_checked++;
         command_count[want.command]++;
         if (stop !== want.silence) begin
            $display("%0t: silence expected %0b actual %0b", $time, want.silence, stop);
            errors++;
         end
         if (cmd !== want.command) begin
            $display("%0t: command expected %0d actual %0d", $time, want.command, cmd);
            errors++;
         end
         if (arg !== want.argument) begin
            $display("%0t: argument expected %0d actual %0d", $time, want.argument, arg);
            errors++;
         end
         if (lvl !== want.level) begin
            $display("%0t: debounced_state expected %b actual %b", $time, want.level, lvl);
            errors++;
         end
      endfunction

      function void flush_leftovers();
         if (expected_decisions.size() != 0) begin
            $display("%0t: %0d expected decisions never arrived", $time,
                     expected_decisions.size());
            errors += expected_decisions.size();
            expected_decisions.delete();
         end
      endfunction
   endclass

endpackage

// ===== tb/button_gesture_decoder_top_tb.sv =====
module button_gesture_decoder_top_tb;
   import bgd_pkg::*;
   import gesture_check_pkg::*;

   localparam int WATCHDOG_TIME   = 3_000_000;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 6;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int DIRECTED_READINGS = 13;

   // each entry is one reading: {level, mode}
   localparam logic [3:0] DIRECTED [DIRECTED_READINGS] = '{
      {LVL_LEFT,  MODE_NORMAL},
      {LVL_NONE,  MODE_NORMAL},
      {LVL_RIGHT, MODE_CUSTOMIZE},
      {LVL_NONE,  MODE_CUSTOMIZE},
      {LVL_BOTH,  MODE_NORMAL},
      {LVL_NONE,  MODE_NORMAL},
      {LVL_BOTH,  MODE_CUSTOMIZE},
      {LVL_BOTH,  MODE_SET_ALARM},
      {LVL_NONE,  MODE_SET_TIME},
      {LVL_LEFT,  MODE_SET_TIME},
      {LVL_NONE,  MODE_SET_ALARM},
      {LVL_RIGHT, MODE_SET_ALARM},
      {LVL_NONE,  MODE_SET_TIME}
   };

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_left_level;
   logic req_right_level;
   logic [1:0] req_mode;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_silence;
   logic [2:0] rsp_command;
   logic signed [ArgWidth-1:0] rsp_argument;
   logic [1:0] rsp_debounced_state;
   logic csr_we;
   logic csr_index;
   logic [CsrWidth-1:0] csr_wdata;

   gesture_scoreboard sb;
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_off_go = 1'b0;
   int samples_sent = 0;
   int settings_written = 0;

   button_gesture_decoder_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_left_level     (req_left_level),
      .req_right_level    (req_right_level),
      .req_mode           (req_mode),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_silence        (rsp_silence),
      .rsp_command        (rsp_command),
      .rsp_argument       (rsp_argument),
      .rsp_debounced_state(rsp_debounced_state),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // values seen here are the ones the block saw at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_sample(req_left_level, req_right_level, mode_type'(req_mode));
         if (rsp_valid && !rsp_stall)
            sb.check_decision(rsp_silence, rsp_command, rsp_argument, rsp_debounced_state);
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_sample(input level_type lvl, input mode_type m);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_left_level  <= lvl[1];
      req_right_level <= lvl[0];
      req_mode        <= m;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   task automatic program_registers(input int stable, input int hold);
      csr_we    <= 1'b1;
      csr_index <= CSR_STABLE_SAMPLES;
      csr_wdata <= stable[CsrWidth-1:0];
      @(posedge clock);
      csr_index <= CSR_HOLD_COUNT;
      csr_wdata <= hold[CsrWidth-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_register(CSR_STABLE_SAMPLES, stable);
      sb.set_register(CSR_HOLD_COUNT, hold);
      settings_written++;
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      // a sample that yields nothing may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly press-and-release gestures sized to the debounce window, some noise
   task automatic random_gestures(input int target);
      int first;
      int win;
      int n;
      int roll;
      bit jitter;
      level_type press;
      mode_type m;
      first = samples_sent;
      while (samples_sent - first < target) begin
         win  = (sb.stable_samples > 1 ? int'(sb.stable_samples) : 1) + 1;
         m    = mode_type'($urandom_range(3));
         roll = $urandom_range(99);
         if (roll < 12) begin
            repeat ($urandom_range(1, 6))
               send_sample(level_type'($urandom_range(3)), mode_type'($urandom_range(3)));
         end else begin
            press  = level_type'($urandom_range(2));
            jitter = ($urandom_range(99) < 15);
            // contact bounce ahead of the press
            if ($urandom_range(99) < 30) send_sample(level_type'($urandom_range(3)), m);
            if (roll < 22)
               n = $urandom_range(1, win - 1);
            else if (m == MODE_NORMAL)
               n = win * $urandom_range(1, int'(sb.hold_count) + 2);
            else
               n = win * $urandom_range(1, 3);
            repeat (n) send_sample(press, jitter ? mode_type'($urandom_range(3)) : m);
            if ($urandom_range(99) < 20) m = mode_type'($urandom_range(3));
            repeat (win) send_sample(LVL_NONE, m);
         end
      end
   endtask

   initial begin
      sb = new();
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_left_level  <= 1'b1;
      req_right_level <= 1'b1;
      req_mode        <= MODE_NORMAL;
      csr_we          <= 1'b0;
      csr_index       <= CSR_STABLE_SAMPLES;
      csr_wdata       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero window and zero hold: every gesture on the shortest path
      program_registers(0, 0);
      for (int i = 0; i < DIRECTED_READINGS; i++)
         repeat (2) send_sample(level_type'(DIRECTED[i][3:2]), mode_type'(DIRECTED[i][1:0]));
      drain();

      program_registers(1, 2);
      random_gestures(150);
      drain();

      program_registers(2, 1);
      idle_pct = 54;
      random_gestures(150);
      drain();

      program_registers(3, 4);
      idle_pct  = 0;
      stall_pct = 54;
      random_gestures(150);
      drain();

      program_registers(1, 3);
      idle_pct  = 14;
      stall_pct = 14;
      random_gestures(150);
      drain();

      // output held off while samples keep coming, so the input side backs up
      program_registers(0, 1);
      idle_pct  = 0;
      stall_pct = 0;
      hold_off_go = 1'b1;
      random_gestures(80);
      drain();

      // left held long enough for the hold timer to saturate
      program_registers(1, 255);
      stall_pct = 30;
      repeat (2 * 260) send_sample(LVL_LEFT, MODE_NORMAL);
      repeat (2) send_sample(LVL_NONE, MODE_NORMAL);
      drain();

      sb.flush_leftovers();
      $display("Run covered %0d samples, %0d decisions, %0d register settings, stalls and a hold-off",
               sb.samples_seen, sb.decisions_checked, settings_written);
      $display("By command: none %0d, mode %0d, time %0d, alarm %0d, type %0d, custom %0d",
               sb.command_count[CMD_NONE], sb.command_count[CMD_SET_MODE],
               sb.command_count[CMD_CHANGE_TIME], sb.command_count[CMD_CHANGE_ALARM],
               sb.command_count[CMD_ALARM_TYPE], sb.command_count[CMD_CUSTOMIZE]);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #WATCHDOG_TIME;
      $display("%0t: timeout", $time);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
